[rtl/rpn_stack_calculator_top_assert.svh]
// ----------------------------------------------------------------------------
// RPN stack calculator assertion macros
// Concurrent check wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_TOP_ASSERT_SVH
`define RPN_STACK_CALCULATOR_TOP_ASSERT_SVH

`ifndef SYNTH
`define RSC_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsc assertion failed");
`define RSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsc assertion failed");
`else
`define RSC_ASSERT_IMPLIES(lbl, ante, cons)
`define RSC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/rsc_pkg.sv]
// ----------------------------------------------------------------------------
// RPN stack calculator package
// Shared types, codes and constants.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int DATA_W          = 32;
  localparam int OPERAND_W       = 31;
  localparam int KIND_W          = 3;
  localparam int STATUS_W        = 2;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int CNT_W           = $clog2(DATA_W);

  typedef enum logic [KIND_W-1:0] {
    KIND_NUM   = 3'd0,
    KIND_ADD   = 3'd1,
    KIND_SUB   = 3'd2,
    KIND_MUL   = 3'd3,
    KIND_DIV   = 3'd4,
    KIND_PRINT = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_UNDER   = 2'd1,
    STAT_OVER    = 2'd2,
    STAT_DIVZERO = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_FIN
  } alu_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RD_R,
    ST_RD_L,
    ST_EXEC,
    ST_RD_P,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

endpackage

[rtl/rpn_stack_calculator_top.sv]
// ----------------------------------------------------------------------------
// RPN stack calculator top level
// Token sequencer around the operand store and the shared arithmetic unit.
// Divide time is set by the one-bit-per-cycle divide loop.
// One token at a time: tready is high only between tokens.
// Reset (rst, synchronous): stack empty, no result pending.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_top
  import rsc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [DATA_W-1:0]   s_tdata,   // [30:0] operand, [31] zero pad
  input  logic [KIND_W-1:0]   s_tuser,   // [2:0] kind
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [DATA_W-1:0]   m_tdata,   // [31:0] value
  output logic [STATUS_W-1:0] m_tuser    // [1:0] status
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  state_t               state;
  state_t               state_next;
  logic [SPW-1:0]       sp;
  logic [SPW-1:0]       sp_next;
  logic [SPW-1:0]       sp_m1;
  logic [SPW-1:0]       sp_m2;
  logic [KIND_W-1:0]    kind_q;
  logic [OPERAND_W-1:0] operand_q;
  logic [DATA_W-1:0]    r_q;
  logic [DATA_W-1:0]    res_value;
  logic [STATUS_W-1:0]  res_status;
  logic                 set_err;
  status_t              err_code;
  logic                 take_pop;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [DATA_W-1:0]    wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [DATA_W-1:0]    rd_data;

  alu_req_t             alu_req;
  alu_rsp_t             alu_rsp;
  logic [DATA_W-1:0]    alu_result;
  logic                 out_load;

  assign sp_m1 = sp - SPW'(1);
  assign sp_m2 = sp - SPW'(2);

  rsc_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rsc_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (rd_data),
    .b      (r_q),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  always_comb begin
    state_next  = state;
    sp_next     = sp;
    s_tready    = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = sp[AW-1:0];
    wr_data     = {1'b0, operand_q};
    rd_en       = 1'b0;
    rd_addr     = sp_m1[AW-1:0];
    alu_req     = '{start: 1'b0, op: ALU_ADD};
    set_err     = 1'b0;
    err_code    = STAT_UNDER;
    take_pop    = 1'b0;
    out_load    = 1'b0;

    case (kind_q)
      KIND_ADD: alu_req.op = ALU_ADD;
      KIND_SUB: alu_req.op = ALU_SUB;
      KIND_MUL: alu_req.op = ALU_MUL;
      default:  alu_req.op = ALU_DIV;
    endcase

    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (kind_q)
          KIND_NUM: begin
            if (sp >= SPW'(STACK_DEPTH)) begin
              set_err  = 1'b1;
              err_code = STAT_OVER;
            end else begin
              wr_en      = 1'b1;
              sp_next    = sp + SPW'(1);
              state_next = ST_IDLE;
            end
          end
          KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
            if (sp < SPW'(2)) begin
              set_err = 1'b1;
            end else begin
              rd_en      = 1'b1;
              state_next = ST_RD_R;
            end
          end
          KIND_PRINT: begin
            if (sp == '0) begin
              set_err = 1'b1;
            end else begin
              rd_en      = 1'b1;
              sp_next    = sp_m1;
              state_next = ST_RD_P;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_RD_R: begin
        rd_en      = 1'b1;
        rd_addr    = sp_m2[AW-1:0];
        state_next = ST_RD_L;
      end
      ST_RD_L: begin
        if (kind_q == KIND_DIV && r_q == '0) begin
          set_err  = 1'b1;
          err_code = STAT_DIVZERO;
        end else begin
          alu_req.start = 1'b1;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        wr_addr = sp_m2[AW-1:0];
        wr_data = alu_result;
        if (alu_rsp.done) begin
          wr_en      = 1'b1;
          sp_next    = sp_m1;
          state_next = ST_IDLE;
        end
      end
      ST_RD_P: begin
        take_pop   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (set_err) begin
      sp_next    = '0;
      state_next = ST_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      sp       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      sp    <= sp_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      kind_q    <= s_tuser;
      operand_q <= s_tdata[OPERAND_W-1:0];
    end
    if (state == ST_RD_R) begin
      r_q <= rd_data;
    end
    if (set_err) begin
      res_value  <= '0;
      res_status <= err_code;
    end else if (take_pop) begin
      res_value  <= rd_data;
      res_status <= STAT_OK;
    end
    if (out_load) begin
      m_tdata <= res_value;
      m_tuser <= res_status;
    end
  end

`include "rpn_stack_calculator_top_assert.svh"

  `RSC_ASSERT_IMPLIES(a_sp_range, 1'b1, sp <= SPW'(STACK_DEPTH))
  `RSC_ASSERT_IMPLIES(a_alu_done_exec, alu_rsp.done, state == ST_EXEC)
  `RSC_ASSERT_IMPLIES(a_alu_start_idle, alu_req.start, !alu_rsp.busy)
  `RSC_ASSERT_NEXT(a_err_empties, set_err, sp == '0 && state == ST_EMIT)
  `RSC_ASSERT_IMPLIES(a_wr_state, wr_en, state == ST_DECODE || state == ST_EXEC)

endmodule

[rtl/rsc_stack.sv]
// ----------------------------------------------------------------------------
// RPN stack calculator operand store
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module rsc_stack
  import rsc_pkg::*;
#(
  parameter int DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/rsc_alu.sv]
// ----------------------------------------------------------------------------
// RPN stack calculator arithmetic unit
// Add, subtract and multiply are registered straight from the request; signed divide one bit per cycle.
// ----------------------------------------------------------------------------
module rsc_alu
  import rsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  alu_req_t          req,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output alu_rsp_t          rsp,
  output logic [DATA_W-1:0] result
);

  alu_state_t          astate;
  alu_state_t          astate_next;
  logic                done;
  logic [DATA_W-1:0]   rem;
  logic [DATA_W-1:0]   quo;
  logic [DATA_W-1:0]   divisor;
  logic                neg;
  logic [CNT_W-1:0]    cnt;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W:0]     rem_sh;
  logic [DATA_W:0]     diff;

  assign prod   = a * b;
  assign rem_sh = {rem, quo[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, divisor};

  always_comb begin
    astate_next = astate;
    case (astate)
      A_IDLE: begin
        if (req.start && req.op == ALU_DIV) begin
          astate_next = A_DIV;
        end
      end
      A_DIV: begin
        if (cnt == CNT_W'(DATA_W - 1)) begin
          astate_next = A_FIN;
        end
      end
      A_FIN:   astate_next = A_IDLE;
      default: astate_next = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      astate <= A_IDLE;
      done   <= 1'b0;
    end else begin
      astate <= astate_next;
      done   <= (astate == A_IDLE && req.start && req.op != ALU_DIV) ||
                (astate == A_FIN);
    end
  end

  always_ff @(posedge clk) begin
    case (astate)
      A_IDLE: begin
        if (req.start) begin
          case (req.op)
            ALU_ADD: result <= a + b;
            ALU_SUB: result <= a - b;
            ALU_MUL: result <= prod[DATA_W-1:0];
            default: begin
              rem     <= '0;
              quo     <= a[DATA_W-1] ? -a : a;
              divisor <= b[DATA_W-1] ? -b : b;
              neg     <= a[DATA_W-1] ^ b[DATA_W-1];
              cnt     <= '0;
            end
          endcase
        end
      end
      A_DIV: begin
        if (!diff[DATA_W]) begin
          rem <= diff[DATA_W-1:0];
          quo <= {quo[DATA_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DATA_W-1:0];
          quo <= {quo[DATA_W-2:0], 1'b0};
        end
        cnt <= cnt + CNT_W'(1);
      end
      A_FIN: begin
        result <= neg ? -quo : quo;
      end
      default: ;
    endcase
  end

  assign rsp.busy = (astate != A_IDLE);
  assign rsp.done = done;

endmodule
